// ----- hdl/luma_histogram_peak_normalize_core_defines.svh -----
// ----------------------------------------------------------------------------
// Luma histogram assertion macros
// Shared property shorthands for the checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LUMA_HISTOGRAM_PEAK_NORMALIZE_CORE_DEFINES_SVH
`define LUMA_HISTOGRAM_PEAK_NORMALIZE_CORE_DEFINES_SVH

// Same-cycle implication.
`define LHPN_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lhpn checker: same-cycle implication failed");

// Next-cycle implication.
`define LHPN_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lhpn checker: next-cycle implication failed");

`endif

// ----- hdl/lhpn_pkg.sv -----
// ----------------------------------------------------------------------------
// Luma histogram package
// Command codes, request and status types and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhpn_pkg;

  localparam int unsigned IN_W      = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned PCT_MAX   = 100;
  // Twice the percent scale, so that adding the peak rounds half up.
  localparam int unsigned PCT_SCALE = 200;

  typedef enum logic [1:0] {
    CMD_ACCUMULATE = 2'd0,
    CMD_READ       = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [IN_W-1:0] index;
    logic            in_range;
  } lhpn_req_t;

  typedef struct packed {
    logic pop;
    logic ready;
  } lhpn_back_stat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACC_WR,
    ST_RD_DATA,
    ST_RD_MUL,
    ST_RD_DIV,
    ST_CLEAR
  } back_state_e;

endpackage

`default_nettype wire

// ----- hdl/lhpn_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpn_ram #(
  parameter int unsigned WIDTH = 19,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/lhpn_div.sv -----
// ----------------------------------------------------------------------------
// Percentage divider
// Restoring division, one quotient bit per cycle, for a quotient that is
// known to fit in PCT_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpn_div
  import lhpn_pkg::*;
#(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [PCT_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(PCT_W);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] dsr_q, dsr_d;
  logic [PCT_W-1:0] quo_q, quo_d;
  logic             ge;

  assign ge = (rem_q >= dsr_q);

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = num_i;
      // The divisor starts aligned with the top quotient bit.
      dsr_d = NUM_W'({den_i, {(PCT_W-1){1'b0}}});
      quo_d = '0;
    end else if (run_q) begin
      if (ge) begin
        rem_d = rem_q - dsr_q;
      end
      quo_d = {quo_q[PCT_W-2:0], ge};
      dsr_d = dsr_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(PCT_W-1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- hdl/lhpn_front.sv -----
// ----------------------------------------------------------------------------
// Histogram front end
// Takes requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpn_front
  import lhpn_pkg::*;
#(
  parameter int unsigned BIN_COUNT = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire logic [1:0]      command_i,
  input  wire logic [IN_W-1:0] pixel_value_i,
  input  wire logic [IN_W-1:0] bin_index_i,
  input  wire lhpn_back_stat_t stat_i,
  output lhpn_req_t            req_o,
  output logic                 req_valid_o
);

  lhpn_req_t  ent;
  logic       keep;
  logic       push;
  logic       pix_ok;
  logic       bin_ok;
  logic       full;
  logic       empty;

  lhpn_req_t  q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign pix_ok = ({{(32-IN_W){1'b0}}, pixel_value_i} < 32'(BIN_COUNT));
  assign bin_ok = ({{(32-IN_W){1'b0}}, bin_index_i} < 32'(BIN_COUNT));

  // Pixels outside the bins and the unused command code never enter the queue.
  always_comb begin
    ent.cmd      = CMD_ACCUMULATE;
    ent.index    = pixel_value_i;
    ent.in_range = pix_ok;
    keep         = 1'b0;
    unique case (command_i)
      CMD_ACCUMULATE: begin
        keep = pix_ok;
      end
      CMD_READ: begin
        ent.cmd      = CMD_READ;
        ent.index    = bin_index_i;
        ent.in_range = bin_ok;
        keep         = 1'b1;
      end
      CMD_CLEAR: begin
        ent.cmd      = CMD_CLEAR;
        ent.index    = '0;
        ent.in_range = 1'b1;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full   = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign busy_o = full || !stat_i.ready;
  assign push   = start_i && !busy_o && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (stat_i.pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    priority if (push && !stat_i.pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && stat_i.pop) begin
      cnt_d = cnt_q - 2'd1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= ent;
    end
  end

  assign req_o       = q_q[rd_ptr_q];
  assign req_valid_o = !empty;

endmodule

`default_nettype wire

// ----- hdl/lhpn_back.sv -----
// ----------------------------------------------------------------------------
// Histogram back end
// Executes queued requests on the bin memory: count, read with percentage,
// and clearing sweeps. Tracks the peak count and its lowest bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpn_back
  import lhpn_pkg::*;
#(
  parameter int unsigned BIN_COUNT  = 256,
  parameter int unsigned COUNT_BITS = 19
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lhpn_req_t              req_i,
  input  wire logic                   req_valid_i,
  output lhpn_back_stat_t             stat_o,
  output logic                        result_valid_o,
  output logic      [COUNT_BITS-1:0]  bin_count_o,
  output logic      [PCT_W-1:0]       percent_of_peak_o,
  output logic      [IN_W-1:0]        peak_bin_o,
  output logic      [COUNT_BITS-1:0]  peak_count_o,
  output logic                        empty_flag_o
);

  localparam int unsigned IDX_W = $clog2(BIN_COUNT);
  localparam int unsigned NUM_W = COUNT_BITS + 8;
  localparam int unsigned DEN_W = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  back_state_e             state_q, state_d;
  lhpn_req_t               cur_q;
  logic [IDX_W-1:0]        clr_cnt_q;
  logic [COUNT_BITS-1:0]   peak_val_q;
  logic [IN_W-1:0]         peak_idx_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic [NUM_W-1:0]        num_q;

  logic                    res_valid_q;
  logic [COUNT_BITS-1:0]   res_cnt_q;
  logic [PCT_W-1:0]        res_pct_q;
  logic [IN_W-1:0]         res_peak_idx_q;
  logic [COUNT_BITS-1:0]   res_peak_val_q;
  logic                    res_empty_q;

  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [COUNT_BITS-1:0]   wdata;
  logic                    re;
  logic [COUNT_BITS-1:0]   rdata;
  logic                    pop;
  logic                    div_start;
  logic                    div_done;
  logic [PCT_W-1:0]        div_quo;
  logic                    emit;
  logic                    clr_last;
  logic                    peak_zero;

  logic [IDX_W+IN_W-1:0]   head_ext;
  logic [IDX_W+IN_W-1:0]   cur_ext;
  logic [IDX_W-1:0]        head_addr;
  logic [IDX_W-1:0]        cur_addr;
  logic [COUNT_BITS-1:0]   c_new;
  logic [COUNT_BITS-1:0]   c_rd;

  assign head_ext  = {{IDX_W{1'b0}}, req_i.index};
  assign cur_ext   = {{IDX_W{1'b0}}, cur_q.index};
  assign head_addr = head_ext[IDX_W-1:0];
  assign cur_addr  = cur_ext[IDX_W-1:0];

  assign c_new     = (rdata == CNT_MAX) ? rdata : rdata + COUNT_BITS'(1);
  assign c_rd      = cur_q.in_range ? rdata : '0;
  assign clr_last  = (clr_cnt_q == IDX_W'(BIN_COUNT-1));
  assign peak_zero = (peak_val_q == '0);

  lhpn_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (head_addr),
    .rdata_o (rdata)
  );

  lhpn_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({peak_val_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (req_i.cmd)
            CMD_ACCUMULATE: state_d = ST_ACC_WR;
            CMD_READ:       state_d = ST_RD_DATA;
            CMD_CLEAR:      state_d = ST_CLEAR;
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC_WR:  state_d = ST_IDLE;
      ST_RD_DATA: state_d = ST_RD_MUL;
      ST_RD_MUL:  state_d = peak_zero ? ST_IDLE : ST_RD_DIV;
      ST_RD_DIV: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    we        = 1'b0;
    waddr     = clr_cnt_q;
    wdata     = '0;
    re        = 1'b0;
    pop       = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        pop = req_valid_i;
        re  = req_valid_i;
      end
      ST_ACC_WR: begin
        we    = 1'b1;
        waddr = cur_addr;
        wdata = c_new;
      end
      ST_RD_MUL: begin
        div_start = !peak_zero;
        emit      = peak_zero;
      end
      ST_RD_DIV: begin
        emit = div_done;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign stat_o.pop   = pop;
  assign stat_o.ready = (state_q != ST_INIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_cnt_q   <= '0;
      peak_val_q  <= '0;
      peak_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= emit;
      if (state_q == ST_IDLE) begin
        clr_cnt_q <= '0;
      end else if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      if (pop && (req_i.cmd == CMD_CLEAR)) begin
        peak_val_q <= '0;
        peak_idx_q <= '0;
      end else if (state_q == ST_ACC_WR) begin
        // A bin that ties the peak from a lower index takes the peak over.
        if (c_new > peak_val_q) begin
          peak_val_q <= c_new;
          peak_idx_q <= cur_q.index;
        end else if ((c_new == peak_val_q) && (cur_q.index < peak_idx_q)) begin
          peak_idx_q <= cur_q.index;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= req_i;
    end
    if (state_q == ST_RD_DATA) begin
      cnt_q <= c_rd;
      num_q <= NUM_W'(c_rd) * NUM_W'(PCT_SCALE) + NUM_W'(peak_val_q);
    end
    if (emit) begin
      res_cnt_q      <= cnt_q;
      res_pct_q      <= (state_q == ST_RD_DIV) ? div_quo : '0;
      res_peak_idx_q <= peak_idx_q;
      res_peak_val_q <= peak_val_q;
      res_empty_q    <= peak_zero;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign bin_count_o       = res_cnt_q;
  assign percent_of_peak_o = res_pct_q;
  assign peak_bin_o        = res_peak_idx_q;
  assign peak_count_o      = res_peak_val_q;
  assign empty_flag_o      = res_empty_q;

endmodule

`default_nettype wire

// ----- hdl/luma_histogram_peak_normalize_core.sv -----
// ----------------------------------------------------------------------------
// Luma histogram with peak-normalized read-out
// Counts 8-bit luma samples into bins, tracks the peak bin, and reports a
// bin's count as a rounded percentage of the peak.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low.
//   command_i selects accumulate (pixel_value_i), read (bin_index_i) or
//   clear. Requests enter a two-entry queue; busy rises when it is full.
//   Only a read gives a result: result_valid_o is high for one cycle with
//   the result fields, and the receiver cannot hold it off.
//   Timing is set by the bin memory and the percentage divider:
//   accumulate is a memory read-modify-write, a read runs the memory
//   read, scaling multiply, 7 divider steps and the hand-off, with the
//   divider skipped while the histogram is empty, and a clear sweeps
//   BIN_COUNT bins, one bin zeroed per cycle.
//   With the back end idle, the result strobe follows the read through
//   these steps and the result register.
//   Requests wait in the queue while earlier ones run.
//   After reset the block sweeps all BIN_COUNT bins to zero and holds busy
//   high while it sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module luma_histogram_peak_normalize_core
  import lhpn_pkg::*;
#(
  parameter int unsigned BIN_COUNT  = 256,
  parameter int unsigned COUNT_BITS = 19
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            command_i,
  input  wire logic [IN_W-1:0]       pixel_value_i,
  input  wire logic [IN_W-1:0]       bin_index_i,
  output logic                       result_valid_o,
  output logic      [COUNT_BITS-1:0] bin_count_o,
  output logic      [PCT_W-1:0]      percent_of_peak_o,
  output logic      [IN_W-1:0]       peak_bin_o,
  output logic      [COUNT_BITS-1:0] peak_count_o,
  output logic                       empty_flag_o
);

  lhpn_req_t       req;
  logic            req_valid;
  lhpn_back_stat_t stat;

  lhpn_front #(
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .command_i     (command_i),
    .pixel_value_i (pixel_value_i),
    .bin_index_i   (bin_index_i),
    .stat_i        (stat),
    .req_o         (req),
    .req_valid_o   (req_valid)
  );

  lhpn_back #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req),
    .req_valid_i       (req_valid),
    .stat_o            (stat),
    .result_valid_o    (result_valid_o),
    .bin_count_o       (bin_count_o),
    .percent_of_peak_o (percent_of_peak_o),
    .peak_bin_o        (peak_bin_o),
    .peak_count_o      (peak_count_o),
    .empty_flag_o      (empty_flag_o)
  );

endmodule

`default_nettype wire

// ----- hdl/lhpn_checker.sv -----
// ----------------------------------------------------------------------------
// Luma histogram checker
// Port-level properties of the read results, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "luma_histogram_peak_normalize_core_defines.svh"

module lhpn_checker
  import lhpn_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 19
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  result_valid_o,
  input wire logic [COUNT_BITS-1:0] bin_count_o,
  input wire logic [PCT_W-1:0]      percent_of_peak_o,
  input wire logic [COUNT_BITS-1:0] peak_count_o,
  input wire logic                  empty_flag_o
);

  `LHPN_ASSERT_IMPLY(a_pct_range, result_valid_o, percent_of_peak_o <= PCT_W'(PCT_MAX))
  `LHPN_ASSERT_IMPLY(a_empty_zero, result_valid_o && empty_flag_o, (percent_of_peak_o == '0) && (peak_count_o == '0))
  `LHPN_ASSERT_IMPLY(a_bin_le_peak, result_valid_o, bin_count_o <= peak_count_o)
  `LHPN_ASSERT_IMPLY(a_peak_full, result_valid_o && !empty_flag_o && (bin_count_o == peak_count_o), percent_of_peak_o == PCT_W'(PCT_MAX))
  `LHPN_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o)

endmodule

bind luma_histogram_peak_normalize_core lhpn_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_lhpn_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .result_valid_o    (result_valid_o),
  .bin_count_o       (bin_count_o),
  .percent_of_peak_o (percent_of_peak_o),
  .peak_count_o      (peak_count_o),
  .empty_flag_o      (empty_flag_o)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Luma histogram peak-normalize core testbench
// Drives accumulate, read, clear and unused command requests into the core
// and keeps a cycle-free model of the bins and the peak. Every read result is
// checked field by field against the model. The run covers directed corner
// cases and randomized request streams under several sender idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lhpn_pkg::*;

  localparam int unsigned NUM_BINS     = 256;
  localparam int unsigned COUNT_W      = 19;
  localparam int unsigned COUNT_TOP    = (1 << COUNT_W) - 1;
  localparam int unsigned HOT_N        = 6;
  localparam int unsigned PHASE_ITEMS  = 160;
  // Command code that the core ignores.
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [IN_W-1:0] pixel;
    logic [IN_W-1:0] bin;
  } pix_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [PCT_W-1:0]   pct;
    logic [IN_W-1:0]    peak_bin;
    logic [COUNT_W-1:0] peak_count;
    logic               empty;
  } bin_report_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic [1:0]         command_i      = 2'd0;
  logic [IN_W-1:0]    pixel_value_i  = '0;
  logic [IN_W-1:0]    bin_index_i    = '0;
  logic               busy;
  logic               result_valid_o;
  logic [COUNT_W-1:0] bin_count_o;
  logic [PCT_W-1:0]   percent_of_peak_o;
  logic [IN_W-1:0]    peak_bin_o;
  logic [COUNT_W-1:0] peak_count_o;
  logic               empty_flag_o;

  pix_req_t    pending_req[$];
  bin_report_t expected_reports[$];

  logic [COUNT_W-1:0] bin_tally[NUM_BINS];
  logic [COUNT_W-1:0] peak_tally;
  logic [IN_W-1:0]    peak_pos;

  int unsigned send_idle   = 0;
  int unsigned err_cnt     = 0;
  int unsigned n_acc       = 0;
  int unsigned n_read      = 0;
  int unsigned n_clear     = 0;
  int unsigned n_unused    = 0;
  int unsigned n_checked   = 0;
  logic [IN_W-1:0] hot_bins[HOT_N];

  luma_histogram_peak_normalize_core #(
    .BIN_COUNT (NUM_BINS),
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .pixel_value_i    (pixel_value_i),
    .bin_index_i      (bin_index_i),
    .result_valid_o   (result_valid_o),
    .bin_count_o      (bin_count_o),
    .percent_of_peak_o(percent_of_peak_o),
    .peak_bin_o       (peak_bin_o),
    .peak_count_o     (peak_count_o),
    .empty_flag_o     (empty_flag_o)
  );

  always #6 clk_i = ~clk_i;

  // Applies one accepted request to the histogram image and queues the
  // report that a read is due to return.
  function automatic void histo_track(logic [1:0] cmd, logic [IN_W-1:0] pix,
                                      logic [IN_W-1:0] bidx);
    bin_report_t        rep;
    logic [COUNT_W-1:0] cnt;
    longint unsigned    num;
    longint unsigned    den;
    case (cmd)
      CMD_ACCUMULATE: begin
        if (pix < NUM_BINS) begin
          cnt = bin_tally[pix];
          if (cnt != COUNT_TOP[COUNT_W-1:0]) cnt = cnt + 1'b1;
          bin_tally[pix] = cnt;
          if (cnt > peak_tally) begin
            peak_tally = cnt;
            peak_pos   = pix;
          end else if (cnt == peak_tally && pix < peak_pos) begin
            peak_pos = pix;
          end
        end
      end
      CMD_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        peak_tally = '0;
        peak_pos   = '0;
      end
      CMD_READ: begin
        cnt = (bidx < NUM_BINS) ? bin_tally[bidx] : '0;
        rep.bin_count  = cnt;
        rep.pct        = '0;
        if (peak_tally != 0) begin
          num     = PCT_SCALE * longint'(cnt) + longint'(peak_tally);
          den     = 2 * longint'(peak_tally);
          rep.pct = PCT_W'(num / den);
        end
        rep.peak_bin   = peak_pos;
        rep.peak_count = peak_tally;
        rep.empty      = (peak_tally == 0);
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  function automatic pix_req_t make_random_req();
    pix_req_t    r;
    int unsigned sel;
    sel     = $urandom_range(99);
    r.pixel = ($urandom_range(99) < 70) ? hot_bins[$urandom_range(HOT_N-1)]
                                        : IN_W'($urandom);
    r.bin   = ($urandom_range(99) < 60) ? hot_bins[$urandom_range(HOT_N-1)]
                                        : IN_W'($urandom);
    if (sel < 62) r.cmd = CMD_ACCUMULATE;
    else if (sel < 94) r.cmd = CMD_READ;
    else if (sel < 96) r.cmd = CMD_CLEAR;
    else r.cmd = CMD_UNUSED;
    return r;
  endfunction

  task automatic push_req(logic [1:0] cmd, logic [IN_W-1:0] pix, logic [IN_W-1:0] bidx);
    pix_req_t r;
    r.cmd   = cmd;
    r.pixel = pix;
    r.bin   = bidx;
    pending_req.push_back(r);
  endtask

  // Checked on the falling edge, when all edge updates have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_req.size() != 0 || start || expected_reports.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    pix_req_t nxt;
    if (!rst_ni) begin
      start         <= 1'b0;
      command_i     <= CMD_ACCUMULATE;
      pixel_value_i <= '0;
      bin_index_i   <= '0;
    end else begin
      if (start && !busy) begin
        histo_track(command_i, pixel_value_i, bin_index_i);
        case (command_i)
          CMD_ACCUMULATE: n_acc++;
          CMD_READ:       n_read++;
          CMD_CLEAR:      n_clear++;
          default:        n_unused++;
        endcase
      end
      if (!start || !busy) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = pending_req.pop_front();
          start         <= 1'b1;
          command_i     <= nxt.cmd;
          pixel_value_i <= nxt.pixel;
          bin_index_i   <= nxt.bin;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : report_monitor
    bin_report_t exp_rep;
    if (rst_ni && result_valid_o) begin
      if (expected_reports.size() == 0) begin
        $error("read result with no read request outstanding");
        err_cnt++;
      end else begin
        exp_rep = expected_reports.pop_front();
        n_checked++;
        if (bin_count_o !== exp_rep.bin_count) begin
          $error("bin_count: expected %0d, got %0d", exp_rep.bin_count, bin_count_o);
          err_cnt++;
        end
        if (percent_of_peak_o !== exp_rep.pct) begin
          $error("percent_of_peak: expected %0d, got %0d", exp_rep.pct, percent_of_peak_o);
          err_cnt++;
        end
        if (peak_bin_o !== exp_rep.peak_bin) begin
          $error("peak_bin: expected %0d, got %0d", exp_rep.peak_bin, peak_bin_o);
          err_cnt++;
        end
        if (peak_count_o !== exp_rep.peak_count) begin
          $error("peak_count: expected %0d, got %0d", exp_rep.peak_count, peak_count_o);
          err_cnt++;
        end
        if (empty_flag_o !== exp_rep.empty) begin
          $error("empty_flag: expected %0d, got %0d", exp_rep.empty, empty_flag_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int unsigned idle_mix[4];
    int unsigned counted;
    pix_req_t    r;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    peak_tally = '0;
    peak_pos   = '0;
    idle_mix   = '{0, 82, 26, 0};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Empty histogram, ties at the peak, rounding and the unused command.
    push_req(CMD_READ, 8'h00, 8'h00);
    push_req(CMD_READ, 8'hff, 8'hff);
    push_req(CMD_UNUSED, 8'hff, 8'hff);
    push_req(CMD_ACCUMULATE, 8'hff, 8'h00);
    push_req(CMD_READ, 8'h00, 8'hff);
    push_req(CMD_READ, 8'hff, 8'h00);
    push_req(CMD_ACCUMULATE, 8'h00, 8'hff);
    push_req(CMD_READ, 8'h00, 8'h80);
    push_req(CMD_ACCUMULATE, 8'hc8, 8'h00);
    push_req(CMD_ACCUMULATE, 8'hc8, 8'h00);
    push_req(CMD_ACCUMULATE, 8'h00, 8'h00);
    push_req(CMD_READ, 8'h00, 8'h00);
    push_req(CMD_ACCUMULATE, 8'hff, 8'h00);
    push_req(CMD_ACCUMULATE, 8'hff, 8'h00);
    push_req(CMD_READ, 8'h00, 8'h00);
    push_req(CMD_READ, 8'h00, 8'hc8);
    push_req(CMD_ACCUMULATE, 8'haa, 8'h55);
    push_req(CMD_ACCUMULATE, 8'h55, 8'haa);
    push_req(CMD_READ, 8'h55, 8'haa);
    push_req(CMD_CLEAR, 8'h00, 8'h00);
    push_req(CMD_READ, 8'hff, 8'hff);
    push_req(CMD_READ, 8'h00, 8'h00);
    push_req(CMD_UNUSED, 8'h00, 8'h00);
    wait_drained();

    foreach (idle_mix[p]) begin
      send_idle = idle_mix[p];
      foreach (hot_bins[h]) hot_bins[h] = IN_W'($urandom);
      if (p == 1) hot_bins[0] = 8'h00;
      if (p == 2) hot_bins[0] = 8'hff;
      // Each half is drained before the next starts, so the sender pauses
      // with every report delivered.
      for (int half = 0; half < 2; half++) begin
        counted = 0;
        while (counted < PHASE_ITEMS / 2) begin
          r = make_random_req();
          pending_req.push_back(r);
          if (r.cmd != CMD_UNUSED) counted++;
        end
        wait_drained();
      end
    end

    // A clear gives no report and may still be sweeping the bins.
    repeat (NUM_BINS + 20) @(posedge clk_i);

    $display("Requests taken: %0d accumulate, %0d read, %0d clear, %0d unused command.",
             n_acc, n_read, n_clear, n_unused);
    $display("Read reports checked: %0d, sender idle mixes 0/82/26 percent.",
             n_checked);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
